// ===== rtl/core/srps_pkg.sv =====
// Package for the periodic SRTF scheduler core.
// Holds field widths, default parameters, action codes and the
// controller/datapath command and status structs. No dependencies.
package srps_pkg;

  localparam int unsigned MaxTasksDef = 8;
  localparam int unsigned TimeBitsDef = 16;

  localparam int unsigned IdxW    = 3;
  localparam int unsigned FieldW  = 16;
  localparam int unsigned CountW  = 4;
  localparam int unsigned TickW   = 32;
  localparam int unsigned ChosenW = 4;

  typedef enum logic {
    ActSet  = 1'b0,
    ActTick = 1'b1
  } action_e;

  typedef struct packed {
    logic set_wr;    // write task parameters from the input word
    logic scan_clr;  // start a tick: clear scan index and best candidate
    logic scan_en;   // process one slot
    logic commit;    // grant, decrement, load result register
  } srps_cmd_t;

  typedef struct packed {
    logic empty;     // no active slots
    logic last;      // scan index is on the last active slot
  } srps_sts_t;

endpackage

// ===== rtl/core/srps_if.sv =====
// Valid/ready channel interfaces for the scheduler core.
// Input word carries a set-task or tick request, output word a grant.
// Depends on srps_pkg.
interface srps_in_if import srps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [IdxW-1:0]   task_index;
  logic [FieldW-1:0] comp_time;
  logic [FieldW-1:0] period;
  logic [FieldW-1:0] rel_deadline;

  modport source (output valid, action, task_index, comp_time, period, rel_deadline,
                  input ready);
  modport sink   (input valid, action, task_index, comp_time, period, rel_deadline,
                  output ready);
endinterface

interface srps_out_if import srps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TickW-1:0]   tick_time;
  logic [ChosenW-1:0] chosen_task;
  logic [FieldW-1:0]  remaining_work;
  logic [TickW-1:0]   current_deadline;

  modport source (output valid, tick_time, chosen_task, remaining_work, current_deadline,
                  input ready);
  modport sink   (input valid, tick_time, chosen_task, remaining_work, current_deadline,
                  output ready);
endinterface

// ===== rtl/core/srps_ctrl.sv =====
// Sequencing FSM for the scheduler core: accepts words, steps the
// slot scan, and commits the grant into the output register.
// Depends on srps_pkg.
module srps_ctrl import srps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_action_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  srps_sts_t sts_i,
  output srps_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    Idle,
    Scan,
    Grant
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  always_comb begin
    in_ready_o      = (state_q == Idle);
    accept          = in_valid_i && in_ready_o;
    cmd_o.set_wr    = accept && (in_action_i == ActSet);
    cmd_o.scan_clr  = accept && (in_action_i == ActTick);
    cmd_o.scan_en   = (state_q == Scan) && !sts_i.empty;
    // hold the grant while a previous word is still waiting downstream
    cmd_o.commit    = (state_q == Grant) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        Idle: begin
          if (cmd_o.scan_clr) state_q <= Scan;
        end
        Scan: begin
          if (sts_i.empty || sts_i.last) state_q <= Grant;
        end
        Grant: begin
          if (cmd_o.commit) state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase

      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/srps_dp.sv =====
// Datapath of the scheduler core: task tables, release/min scan over
// one slot per cycle, grant decrement and the output register.
// Depends on srps_pkg.
module srps_dp import srps_pkg::*; #(
  parameter int unsigned MAX_TASKS = MaxTasksDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srps_cmd_t          cmd_i,
  output srps_sts_t          sts_o,
  input  logic               cfg_we_i,
  input  logic [CountW-1:0]  cfg_wdata_i,
  input  logic [IdxW-1:0]    task_index_i,
  input  logic [FieldW-1:0]  comp_time_i,
  input  logic [FieldW-1:0]  period_i,
  input  logic [FieldW-1:0]  rel_deadline_i,
  output logic [TickW-1:0]   tick_time_o,
  output logic [ChosenW-1:0] chosen_task_o,
  output logic [FieldW-1:0]  remaining_work_o,
  output logic [TickW-1:0]   current_deadline_o
);

  localparam int unsigned TW   = TIME_BITS;
  localparam int unsigned IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW   = $clog2(MAX_TASKS + 1);
  localparam int unsigned ExtW = (TW > FieldW) ? TW : FieldW;

  logic [TW-1:0]    rem_q    [MAX_TASKS];
  logic [TW-1:0]    cd_q     [MAX_TASKS];
  logic [TW-1:0]    comp_q   [MAX_TASKS];
  logic [TW-1:0]    per_q    [MAX_TASKS];
  logic [TW-1:0]    reldl_q  [MAX_TASKS];
  logic [TickW-1:0] absdl_q  [MAX_TASKS];

  logic [CountW-1:0] task_count_q;
  logic [CW-1:0]     last_granted_q;
  logic [TickW-1:0]  tick_q;
  logic [IW-1:0]     scan_idx_q;
  logic              best_vld_q;
  logic [IW-1:0]     best_idx_q;
  logic [TW-1:0]     best_rem_q;
  logic [TickW-1:0]  best_dl_q;

  logic [CW-1:0]     active;
  logic [CW-1:0]     scan_num;
  logic [CW-1:0]     best_num;
  logic [ExtW-1:0]   comp_ext, per_ext, reldl_ext;
  logic              set_ok;
  logic [IW-1:0]     set_idx;

  // slot under scan
  logic [TW-1:0]     rd_rem, rd_cd, rd_comp, rd_per, rd_reldl;
  logic [TickW-1:0]  rd_absdl;
  logic [TW:0]       rem_sum;
  logic              release_now, add_job;
  logic [TW-1:0]     rem_new, cd_new;
  logic [TickW-1:0]  absdl_new;
  logic              take;

  always_comb begin
    active   = (32'(task_count_q) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_count_q);
    scan_num = CW'(scan_idx_q) + CW'(1);
    best_num = CW'(best_idx_q) + CW'(1);
    sts_o.empty = (active == '0);
    sts_o.last  = (CW'(scan_idx_q) == active - CW'(1));

    comp_ext  = ExtW'(comp_time_i);
    per_ext   = ExtW'(period_i);
    reldl_ext = ExtW'(rel_deadline_i);
    set_ok    = (32'(task_index_i) < MAX_TASKS);
    set_idx   = IW'(task_index_i);

    rd_rem   = rem_q[scan_idx_q];
    rd_cd    = cd_q[scan_idx_q];
    rd_comp  = comp_q[scan_idx_q];
    rd_per   = per_q[scan_idx_q];
    rd_reldl = reldl_q[scan_idx_q];
    rd_absdl = absdl_q[scan_idx_q];

    release_now = (rd_cd == '0);
    add_job     = release_now && (rd_comp != '0);
    rem_sum     = {1'b0, rd_rem} + {1'b0, rd_comp};
    rem_new     = rd_rem;
    absdl_new   = rd_absdl;
    if (add_job) begin
      rem_new   = rem_sum[TW] ? '1 : rem_sum[TW-1:0];
      absdl_new = tick_q + TickW'(rd_reldl);
    end
    // period zero behaves as one
    if (release_now) begin
      cd_new = (rd_per == '0) ? '0 : rd_per - TW'(1);
    end else begin
      cd_new = rd_cd - TW'(1);
    end

    // strictly smaller wins; equal wins only for last tick's grantee
    take = (rem_new != '0) &&
           (!best_vld_q || (rem_new < best_rem_q) ||
            ((rem_new == best_rem_q) && (last_granted_q == scan_num)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        rem_q[i]   <= '0;
        cd_q[i]    <= '0;
        comp_q[i]  <= '0;
        per_q[i]   <= TW'(1);
        reldl_q[i] <= '0;
        absdl_q[i] <= '0;
      end
      task_count_q   <= CountW'(1);
      last_granted_q <= '0;
      tick_q         <= '0;
      scan_idx_q     <= '0;
      best_vld_q     <= 1'b0;
      best_idx_q     <= '0;
      best_rem_q     <= '0;
      best_dl_q      <= '0;
    end else begin
      if (cfg_we_i) task_count_q <= cfg_wdata_i;

      if (cmd_i.set_wr && set_ok) begin
        comp_q[set_idx]  <= comp_ext[TW-1:0];
        per_q[set_idx]   <= per_ext[TW-1:0];
        reldl_q[set_idx] <= reldl_ext[TW-1:0];
        cd_q[set_idx]    <= '0;
      end

      if (cmd_i.scan_clr) begin
        scan_idx_q <= '0;
        best_vld_q <= 1'b0;
      end

      if (cmd_i.scan_en) begin
        rem_q[scan_idx_q]   <= rem_new;
        cd_q[scan_idx_q]    <= cd_new;
        absdl_q[scan_idx_q] <= absdl_new;
        scan_idx_q          <= scan_idx_q + IW'(1);
        if (take) begin
          best_vld_q <= 1'b1;
          best_idx_q <= scan_idx_q;
          best_rem_q <= rem_new;
          best_dl_q  <= absdl_new;
        end
      end

      if (cmd_i.commit) begin
        tick_q <= tick_q + TickW'(1);
        if (best_vld_q) begin
          rem_q[best_idx_q] <= best_rem_q - TW'(1);
          last_granted_q    <= best_num;
        end else begin
          last_granted_q    <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      tick_time_o <= tick_q;
      if (best_vld_q) begin
        chosen_task_o      <= ChosenW'(best_num);
        remaining_work_o   <= FieldW'(best_rem_q - TW'(1));
        current_deadline_o <= best_dl_q;
      end else begin
        chosen_task_o      <= '0;
        remaining_work_o   <= '0;
        current_deadline_o <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/shortest_remaining_periodic_scheduler_core.sv =====
// Periodic shortest-remaining-time scheduler core.
// Set-task word: taken with no result. Tick word: the active slots are
// scanned one slot per cycle, then the grant is committed into the output
// register once it is free or being read; next word taken after the commit.
// Input accepted while an earlier result waits in the output register.
// Async active-low reset: tables to reset values, task count 1, tick 0.
module shortest_remaining_periodic_scheduler_core import srps_pkg::*; #(
  parameter int unsigned MAX_TASKS = MaxTasksDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  srps_in_if.sink           in_i,
  srps_out_if.source        out_o
);

  srps_cmd_t cmd;
  srps_sts_t sts;

  srps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srps_dp #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .task_index_i       (in_i.task_index),
    .comp_time_i        (in_i.comp_time),
    .period_i           (in_i.period),
    .rel_deadline_i     (in_i.rel_deadline),
    .tick_time_o        (out_o.tick_time),
    .chosen_task_o      (out_o.chosen_task),
    .remaining_work_o   (out_o.remaining_work),
    .current_deadline_o (out_o.current_deadline)
  );

`ifndef NO_ASSERTIONS
  // a grant never overwrites a word still waiting downstream
  a_commit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_o.valid || out_o.ready))
    else $error("grant committed over a pending result");

  // each grant shows up as a valid word on the next cycle
  a_commit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_o.valid)
    else $error("grant did not produce a result word");

  // no word is taken while a tick is being scanned or granted
  a_accept_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!cmd.scan_en && !cmd.commit))
    else $error("input word accepted during a tick");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for the periodic shortest-remaining-time scheduler core.
// Checks each grant word against an in-bench model of the task tables.
// Depends on srps_pkg, srps_if and shortest_remaining_periodic_scheduler_core.
`timescale 1ns / 100ps

module tb;
  import srps_pkg::*;

  localparam int Slots      = MaxTasksDef;
  localparam int IdlePct    = 37;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    action_e           action;
    logic [IdxW-1:0]   slot;
    logic [FieldW-1:0] comp;
    logic [FieldW-1:0] period;
    logic [FieldW-1:0] reldl;
  } sched_req_t;

  typedef struct packed {
    logic [TickW-1:0]   tick;
    logic [ChosenW-1:0] chosen;
    logic [FieldW-1:0]  work;
    logic [TickW-1:0]   deadline;
  } grant_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  srps_in_if  in_if ();
  srps_out_if out_if ();

  shortest_remaining_periodic_scheduler_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // scheduler model state
  logic [FieldW-1:0] work_tbl     [Slots];
  logic [FieldW-1:0] countdown_tbl[Slots];
  logic [FieldW-1:0] comp_tbl     [Slots];
  logic [FieldW-1:0] period_tbl   [Slots];
  logic [FieldW-1:0] reldl_tbl    [Slots];
  logic [TickW-1:0]  absdl_tbl    [Slots];
  logic [ChosenW-1:0] last_grant;
  logic [TickW-1:0]  tick_now;
  logic [CountW-1:0] slot_count;

  sched_req_t pending_reqs[$];
  grant_t     expected_grants[$];
  sched_req_t drive_req;
  grant_t     got_grant;
  grant_t     want_grant;

  bit offering;
  bit in_taken;
  bit calm;
  bit hold_req;
  int hold_left;
  int fail_count;
  int cycles;

  always #1 clk_i = ~clk_i;

  function automatic grant_t schedule_tick();
    int active;
    int best;
    logic [FieldW:0] sum;
    logic [FieldW-1:0] per;
    grant_t g;
    active = (slot_count > Slots) ? Slots : slot_count;
    for (int i = 0; i < active; i++) begin
      if (countdown_tbl[i] == 0) begin
        per = (period_tbl[i] == 0) ? FieldW'(1) : period_tbl[i];
        if (comp_tbl[i] != 0) begin
          sum = {1'b0, work_tbl[i]} + {1'b0, comp_tbl[i]};
          work_tbl[i] = sum[FieldW] ? '1 : sum[FieldW-1:0];
          absdl_tbl[i] = tick_now + {16'b0, reldl_tbl[i]};
        end
        countdown_tbl[i] = per - FieldW'(1);
      end else begin
        countdown_tbl[i] = countdown_tbl[i] - FieldW'(1);
      end
    end
    best = -1;
    for (int i = 0; i < active; i++) begin
      if (work_tbl[i] == 0) continue;
      if (best < 0 || work_tbl[i] < work_tbl[best]) begin
        best = i;
      end else if (work_tbl[i] == work_tbl[best] && last_grant == i + 1) begin
        best = i;  // previous owner keeps the tick on a tie
      end
    end
    g.tick = tick_now;
    if (best < 0) begin
      g.chosen   = '0;
      g.work     = '0;
      g.deadline = '0;
      last_grant = '0;
    end else begin
      work_tbl[best] = work_tbl[best] - FieldW'(1);
      g.chosen   = ChosenW'(best + 1);
      g.work     = work_tbl[best];
      g.deadline = absdl_tbl[best];
      last_grant = ChosenW'(best + 1);
    end
    tick_now = tick_now + TickW'(1);
    return g;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic sched_req_t rand_req();
    sched_req_t r;
    int pick;
    r.action = ($urandom_range(0, 99) < 22) ? ActSet : ActTick;
    r.slot = IdxW'($urandom_range(0, Slots - 1));
    pick = $urandom_range(0, 99);
    if (pick < 12) r.comp = '0;
    else if (pick < 88) r.comp = FieldW'($urandom_range(1, 6));
    else if (pick < 97) r.comp = FieldW'($urandom_range(7, 300));
    else r.comp = FieldW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) r.period = '0;
    else if (pick < 80) r.period = FieldW'($urandom_range(1, 12));
    else if (pick < 95) r.period = FieldW'($urandom_range(13, 200));
    else r.period = FieldW'($urandom);
    r.reldl = ($urandom_range(0, 1) == 0) ? FieldW'($urandom) : FieldW'($urandom_range(0, 20));
    return r;
  endfunction

  task automatic push_set(int slot, int comp, int period, int reldl);
    sched_req_t r;
    r.action = ActSet;
    r.slot   = IdxW'(slot);
    r.comp   = FieldW'(comp);
    r.period = FieldW'(period);
    r.reldl  = FieldW'(reldl);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic push_ticks(int n);
    sched_req_t r;
    for (int i = 0; i < n; i++) begin
      r = rand_req();
      r.action = ActTick;
      pending_reqs = {pending_reqs, r};
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || offering || expected_grants.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_count(int value);
    drain();
    repeat (20) @(posedge clk_i);  // let a trailing set word settle
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CountW'(value);
    slot_count = CountW'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // accept edge: check grants, then feed accepted words to the model
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      got_grant.tick     = out_if.tick_time;
      got_grant.chosen   = out_if.chosen_task;
      got_grant.work     = out_if.remaining_work;
      got_grant.deadline = out_if.current_deadline;
      if (expected_grants.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected grant word, expected none, got %h", $time, got_grant);
      end else begin
        want_grant = expected_grants.pop_front();
        check_field("tick_time", want_grant.tick, got_grant.tick);
        check_field("chosen_task", 32'(want_grant.chosen), 32'(got_grant.chosen));
        check_field("remaining_work", 32'(want_grant.work), 32'(got_grant.work));
        check_field("current_deadline", want_grant.deadline, got_grant.deadline);
      end
    end
    if (in_if.valid && in_if.ready) begin
      in_taken = 1'b1;
      if (in_if.action == ActTick) begin
        expected_grants = {expected_grants, schedule_tick()};
      end else begin
        comp_tbl[in_if.task_index]      = in_if.comp_time;
        period_tbl[in_if.task_index]    = in_if.period;
        reldl_tbl[in_if.task_index]     = in_if.rel_deadline;
        countdown_tbl[in_if.task_index] = '0;
      end
    end
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (in_taken) begin
      in_taken = 1'b0;
      offering = 1'b0;
    end
    if (rst_ni && !offering && pending_reqs.size() != 0 &&
        (calm || $urandom_range(0, 99) >= IdlePct)) begin
      drive_req = pending_reqs.pop_front();
      in_if.action       <= drive_req.action;
      in_if.task_index   <= drive_req.slot;
      in_if.comp_time    <= drive_req.comp;
      in_if.period       <= drive_req.period;
      in_if.rel_deadline <= drive_req.reldl;
      offering = 1'b1;
    end
    in_if.valid <= offering;
  end

  // grant receiver, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  initial begin
    int phase_counts[7];
    int phase_items[7];
    sched_req_t r;
    phase_counts = '{8, 3, 0, 15, 1, 5, 8};
    phase_items  = '{300, 300, 100, 300, 250, 300, 350};
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.action = ActSet;
    in_if.task_index = '0;
    in_if.comp_time = '0;
    in_if.period = '0;
    in_if.rel_deadline = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      work_tbl[i] = '0;
      countdown_tbl[i] = '0;
      comp_tbl[i] = '0;
      period_tbl[i] = FieldW'(1);
      reldl_tbl[i] = '0;
      absdl_tbl[i] = '0;
    end
    last_grant = '0;
    tick_now = '0;
    slot_count = CountW'(1);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // one slot active out of reset
    push_ticks(1);
    push_set(3, 5, 2, 9);          // outside the active range, stays frozen
    push_set(0, 2, 0, 65535);      // period zero releases every tick
    push_ticks(3);
    push_set(0, 0, 1, 0);          // disabled, drains what it has
    push_ticks(2);
    write_count(0);
    push_ticks(2);                 // nothing active
    write_count(15);               // clamps to all slots
    push_set(7, 65535, 65535, 65535);
    push_set(1, 1, 1, 0);
    push_set(2, 1, 1, 3);
    push_ticks(4);
    push_set(7, 65535, 65535, 65535);
    push_ticks(2);

    for (int p = 0; p < 7; p++) begin
      write_count(phase_counts[p]);
      if (p == 1) calm = 1'b1;
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 0 && n == 100) begin
          drain();
          hold_req = 1'b1;         // stall grants while words keep coming
        end
        r = rand_req();
        pending_reqs = {pending_reqs, r};
      end
      drain();
      calm = 1'b0;
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/srps_pkg.sv
rtl/core/srps_if.sv
rtl/core/srps_ctrl.sv
rtl/core/srps_dp.sv
rtl/core/shortest_remaining_periodic_scheduler_core.sv
tb/tb.sv
